@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; define SYNTHESIS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define PN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// next-cycle implication check
`define PN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define PN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pn3d_pkg.sv @@
// types, constants and arithmetic helpers for the 3d perlin noise unit
// no dependencies
package pn3d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NOISE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [NOISE_W-1:0]   noise_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
  typedef logic signed [18:0]   gval_t;

  // register indexes
  localparam cfg_idx_t CFG_REPEAT  = 2'd0;
  localparam cfg_idx_t CFG_OCTAVES = 2'd1;
  localparam cfg_idx_t CFG_PERSIST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPLIT, ST_WRAP, ST_EVAL1, ST_EVAL2, ST_EVAL3, ST_HASHZ, ST_GRAD,
    ST_LERP1, ST_LERP2, ST_LERP3, ST_ACC, ST_DINIT, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic split;
    logic wrap_step;
    logic eval1;
    logic eval2;
    logic eval3;
    logic hashz;
    logic grad;
    logic lerp1;
    logic lerp2;
    logic lerp3;
    logic acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic wrap_en;
    logic out_busy;
    logic wsum_nz;
  } status_t;

  // permutation table
  localparam logic [7:0] PERM [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
    8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
    35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
    134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
    55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
    18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
    250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
    189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
    172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
    228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
    107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
    138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

  // edge gradient dot product, 16 codes
  function automatic gval_t grad_q(input logic [3:0] h, input logic signed [17:0] x,
                                   input logic signed [17:0] y,
                                   input logic signed [17:0] z);
    gval_t sx, sy, sz, r;
    sx = 19'(x);
    sy = 19'(y);
    sz = 19'(z);
    unique case (h)
      4'd0:    r = sx + sy;
      4'd1:    r = sy - sx;
      4'd2:    r = sx - sy;
      4'd3:    r = -sx - sy;
      4'd4:    r = sx + sz;
      4'd5:    r = sz - sx;
      4'd6:    r = sx - sz;
      4'd7:    r = -sx - sz;
      4'd8:    r = sy + sz;
      4'd9:    r = sz - sy;
      4'd10:   r = sy - sz;
      4'd11:   r = -sy - sz;
      4'd12:   r = sy + sx;
      4'd13:   r = sz - sy;
      4'd14:   r = sy - sx;
      default: r = -sy - sz;
    endcase
    return r;
  endfunction

  // a + (b - a) * t / one, quotient truncated toward zero
  function automatic gval_t lerp_q(input gval_t a, input gval_t b, input logic [16:0] t);
    logic signed [19:0] d;
    logic signed [37:0] p;
    logic signed [37:0] q;
    d = 20'(b) - 20'(a);
    p = 38'(d) * 38'(signed'({1'b0, t}));
    q = (p < 0) ? ((p + 38'sd65535) >>> FRAC_BITS) : (p >>> FRAC_BITS);
    return a + q[18:0];
  endfunction

endpackage

@@ rtl/pn3d_if.sv @@
// channel interfaces for the 3d perlin noise unit
// depends on pn3d_pkg
interface pn3d_in_if import pn3d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  modport source(output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink(input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface pn3d_out_if import pn3d_pkg::*; ();
  logic   valid;
  logic   ready;
  noise_t noise_value;
  modport source(output valid, output noise_value, input ready);
  modport sink(input valid, input noise_value, output ready);
endinterface

interface pn3d_cfg_if import pn3d_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/pn3d_ctrl.sv @@
// sequencing state machine for the 3d perlin noise unit
// depends on pn3d_pkg; drives the datapath through cmd_t
module pn3d_ctrl import pn3d_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] octave_count,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam int CW   = COORD_W + MAX_OCTAVES - 1;
  localparam int IPW  = CW - FRAC_BITS;
  localparam int TW   = 34 + $clog2(MAX_OCTAVES);
  localparam int CNTW = $clog2(TW);
  localparam int OW   = $clog2(MAX_OCTAVES + 1);

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0]   oct_r, oct_nxt;
  logic [OW-1:0]   eff_cnt;
  logic            last_oct;

  // effective octave count, clamped to 1..MAX_OCTAVES
  always_comb begin
    priority if (octave_count == 4'd0) begin
      eff_cnt = OW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      eff_cnt = OW'(MAX_OCTAVES);
    end else begin
      eff_cnt = OW'(octave_count);
    end
  end
  assign last_oct = (oct_r == OW'(eff_cnt - OW'(1)));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      oct_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oct_r   <= oct_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    oct_nxt   = oct_r;
    unique case (state_r)
      ST_IDLE: begin
        oct_nxt = '0;
        if (in_valid) state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        cnt_nxt   = '0;
        state_nxt = status.wrap_en ? ST_WRAP : ST_EVAL1;
      end
      ST_WRAP: begin
        cnt_nxt = CNTW'(cnt_r + 1'b1);
        if (cnt_r == CNTW'(IPW - 1)) state_nxt = ST_EVAL1;
      end
      ST_EVAL1: state_nxt = ST_EVAL2;
      ST_EVAL2: state_nxt = ST_EVAL3;
      ST_EVAL3: state_nxt = ST_HASHZ;
      ST_HASHZ: state_nxt = ST_GRAD;
      ST_GRAD:  state_nxt = ST_LERP1;
      ST_LERP1: state_nxt = ST_LERP2;
      ST_LERP2: state_nxt = ST_LERP3;
      ST_LERP3: state_nxt = ST_ACC;
      ST_ACC: begin
        if (last_oct) begin
          state_nxt = ST_DINIT;
        end else begin
          oct_nxt   = OW'(oct_r + 1'b1);
          state_nxt = ST_SPLIT;
        end
      end
      ST_DINIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = CNTW'(cnt_r + 1'b1);
        if (cnt_r == CNTW'(TW - 1)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SPLIT: cmd.split     = 1'b1;
      ST_WRAP:  cmd.wrap_step = 1'b1;
      ST_EVAL1: cmd.eval1     = 1'b1;
      ST_EVAL2: cmd.eval2     = 1'b1;
      ST_EVAL3: cmd.eval3     = 1'b1;
      ST_HASHZ: cmd.hashz     = 1'b1;
      ST_GRAD:  cmd.grad      = 1'b1;
      ST_LERP1: cmd.lerp1     = 1'b1;
      ST_LERP2: cmd.lerp2     = 1'b1;
      ST_LERP3: cmd.lerp3     = 1'b1;
      ST_ACC:   cmd.acc       = 1'b1;
      ST_DINIT: cmd.div_init  = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_OUT:   cmd.out_load  = !status.out_busy;
      default:  cmd           = '0;
    endcase
  end

endmodule

@@ rtl/pn3d_dp.sv @@
// datapath: lattice split, wrap remainder, fade, hash, gradients, lerps,
// octave accumulation, normalizing divide and the output register
// depends on pn3d_pkg; commanded by pn3d_ctrl
module pn3d_dp import pn3d_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  coord_t      coord_x,
  input  coord_t      coord_y,
  input  coord_t      coord_z,
  input  logic [8:0]  repeat_period,
  input  logic [15:0] persistence,
  output logic        out_valid,
  input  logic        out_ready,
  output noise_t      noise_value
);

  localparam int CW  = COORD_W + MAX_OCTAVES - 1;
  localparam int IPW = CW - FRAC_BITS;
  localparam int TW  = 34 + $clog2(MAX_OCTAVES);
  localparam int WW  = 18 + $clog2(MAX_OCTAVES);

  logic [CW-1:0]  crd_r  [3];
  logic [15:0]    frac_r [3];
  logic [IPW-1:0] ipsh_r [3];
  logic [8:0]     rem_r  [3];
  logic [7:0]     cell_r [3];
  logic [7:0]     nxt_r  [3];
  logic [31:0]    sq_r   [3];
  logic [31:0]    c0_r   [3];
  logic [20:0]    b_r    [3];
  logic [16:0]    fade_r [3];
  logic [7:0]     ax_r   [2];
  logic [7:0]     bb_r   [4];
  logic [7:0]     hh_r   [8];
  gval_t          g_r    [8];
  gval_t          l1_r   [4];
  gval_t          l2_r   [2];
  gval_t          l3_r;
  logic [TW-1:0]  total_r, dvd_r, quo_r;
  logic [WW-1:0]  wsum_r, drem_r;
  logic [16:0]    amp_r;
  logic           out_valid_r;
  noise_t         noise_r;

  logic           wrap_en;
  logic [9:0]     wt     [3];
  logic           wge    [3];
  logic [9:0]     rem_p1 [3];
  logic [WW:0]    dt;
  logic           dge;
  logic signed [19:0] nsum;
  logic [16:0]    nval;
  logic signed [17:0] fx [3];
  logic signed [17:0] gx [3];

  assign wrap_en = (repeat_period != 9'd0);

  // per-lane combinational helpers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wt[i]     = {rem_r[i], ipsh_r[i][IPW-1]};
      wge[i]    = (wt[i] >= {1'b0, repeat_period});
      // next cell counts from the 8-bit cell, not the full remainder
      rem_p1[i] = {2'b0, rem_r[i][7:0]} + 10'd1;
      fx[i]     = 18'(signed'({2'b0, frac_r[i]}));
      gx[i]     = fx[i] - 18'sd65536;
    end
  end

  // octave value remapped to 0..one
  always_comb begin
    nsum = 20'(l3_r) + 20'sd65536;
    priority if (nsum < 0) begin
      nval = '0;
    end else if (nsum[19:1] > 19'd65536) begin
      nval = 17'd65536;
    end else begin
      nval = nsum[17:1];
    end
  end

  // normalizing divide step
  assign dt  = {drem_r, dvd_r[TW-1]};
  assign dge = (dt >= {1'b0, wsum_r});

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crd_r[0] <= CW'(coord_x);
      crd_r[1] <= CW'(coord_y);
      crd_r[2] <= CW'(coord_z);
      total_r  <= '0;
      wsum_r   <= '0;
      amp_r    <= 17'd65536;
    end
    // split into cell and fraction
    if (cmd.split) begin
      for (int i = 0; i < 3; i++) begin
        frac_r[i] <= crd_r[i][15:0];
        ipsh_r[i] <= crd_r[i][CW-1:FRAC_BITS];
        rem_r[i]  <= '0;
      end
    end
    // one remainder bit per cycle against the wrap period
    if (cmd.wrap_step) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[i]  <= wge[i] ? 9'(wt[i] - {1'b0, repeat_period}) : wt[i][8:0];
        ipsh_r[i] <= ipsh_r[i] << 1;
      end
    end
    // cells and first fade product
    if (cmd.eval1) begin
      for (int i = 0; i < 3; i++) begin
        if (wrap_en) begin
          cell_r[i] <= rem_r[i][7:0];
          nxt_r[i]  <= (rem_p1[i] == {1'b0, repeat_period}) ? 8'd0 : rem_p1[i][7:0];
        end else begin
          cell_r[i] <= ipsh_r[i][7:0];
          nxt_r[i]  <= ipsh_r[i][7:0] + 8'd1;
        end
        sq_r[i] <= 32'(frac_r[i]) * 32'(frac_r[i]);
      end
    end
    // x hash and fade polynomial terms
    if (cmd.eval2) begin
      ax_r[0] <= PERM[cell_r[0]];
      ax_r[1] <= PERM[nxt_r[0]];
      for (int i = 0; i < 3; i++) begin
        c0_r[i] <= 32'(sq_r[i][31:16]) * 32'(frac_r[i]);
        b_r[i]  <= 21'(22'd655360 + 22'((35'(sq_r[i]) * 35'd6) >> FRAC_BITS)
                       - 22'(22'(frac_r[i]) * 22'd15));
      end
    end
    // y hash and fade result
    if (cmd.eval3) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          bb_r[j*2+k] <= PERM[8'(ax_r[k] + (j == 1 ? nxt_r[1] : cell_r[1]))];
        end
      end
      for (int i = 0; i < 3; i++) begin
        fade_r[i] <= 17'((37'(c0_r[i][31:16]) * 37'(b_r[i])) >> FRAC_BITS);
      end
    end
    // z hash for all eight corners
    if (cmd.hashz) begin
      for (int l = 0; l < 2; l++) begin
        for (int m = 0; m < 4; m++) begin
          hh_r[l*4+m] <= PERM[8'(bb_r[m] + (l == 1 ? nxt_r[2] : cell_r[2]))];
        end
      end
    end
    // corner gradients
    if (cmd.grad) begin
      for (int c = 0; c < 8; c++) begin
        g_r[c] <= grad_q(hh_r[c][3:0],
                         ((c & 1) != 0) ? gx[0] : fx[0],
                         ((c & 2) != 0) ? gx[1] : fx[1],
                         ((c & 4) != 0) ? gx[2] : fx[2]);
      end
    end
    // trilinear interpolation, one axis per cycle
    if (cmd.lerp1) begin
      for (int m = 0; m < 4; m++) begin
        l1_r[m] <= lerp_q(g_r[m*2], g_r[m*2+1], fade_r[0]);
      end
    end
    if (cmd.lerp2) begin
      for (int m = 0; m < 2; m++) begin
        l2_r[m] <= lerp_q(l1_r[m*2], l1_r[m*2+1], fade_r[1]);
      end
    end
    if (cmd.lerp3) begin
      l3_r <= lerp_q(l2_r[0], l2_r[1], fade_r[2]);
    end
    // weighted accumulation and next octave setup
    if (cmd.acc) begin
      total_r <= total_r + TW'(34'(nval) * 34'(amp_r));
      wsum_r  <= wsum_r + WW'(amp_r);
      amp_r   <= 17'((33'(amp_r) * 33'(persistence)) >> 16);
      for (int i = 0; i < 3; i++) begin
        crd_r[i] <= crd_r[i] << 1;
      end
    end
    // restoring divide, one quotient bit per cycle
    if (cmd.div_init) begin
      dvd_r  <= total_r;
      drem_r <= '0;
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= dge ? WW'(dt - {1'b0, wsum_r}) : dt[WW-1:0];
      quo_r  <= {quo_r[TW-2:0], dge};
      dvd_r  <= dvd_r << 1;
    end
    if (cmd.out_load) begin
      noise_r <= (quo_r > TW'(65535)) ? 16'hFFFF : quo_r[15:0];
    end
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign noise_value     = noise_r;
  assign status.wrap_en  = wrap_en;
  assign status.out_busy = out_valid_r && !out_ready;
  assign status.wsum_nz  = (wsum_r != '0);

endmodule

@@ rtl/perlin_noise_3d_octaves_unit.sv @@
// 3d fractal perlin noise unit: one point in, one normalized Q0.16 value out.
// each octave steps through split, the wrap remainder when repeat_period is nonzero,
// the eval steps, z hash, gradients, the lerps and accumulation; after the last octave
// come the divide init, the restoring divide and the output load. one point at a
// time; in_ready returns in the same cycle that out valid rises.
// synchronous active-low reset: idle, no result, repeat_period 0, 1 octave, persistence 32768.
`include "assert_macros.svh"
module perlin_noise_3d_octaves_unit import pn3d_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input logic        clk,
  input logic        rst_n,
  pn3d_in_if.sink    in_ch,
  pn3d_out_if.source out_ch,
  pn3d_cfg_if.sink   cfg_ch
);

  logic [8:0]  repeat_period_r;
  logic [3:0]  octave_count_r;
  logic [15:0] persistence_r;
  cmd_t        cmd;
  status_t     status;
  logic        in_ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_period_r <= 9'd0;
      octave_count_r  <= 4'd1;
      persistence_r   <= 16'd32768;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_REPEAT:  repeat_period_r <= cfg_ch.data[8:0];
        CFG_OCTAVES: octave_count_r  <= cfg_ch.data[3:0];
        CFG_PERSIST: persistence_r   <= cfg_ch.data;
        default:     ;
      endcase
    end
  end

  pn3d_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .octave_count (octave_count_r),
    .status       (status),
    .cmd          (cmd)
  );

  pn3d_dp #(.MAX_OCTAVES(MAX_OCTAVES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .coord_x       (in_ch.coord_x),
    .coord_y       (in_ch.coord_y),
    .coord_z       (in_ch.coord_z),
    .repeat_period (repeat_period_r),
    .persistence   (persistence_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .noise_value   (out_ch.noise_value)
  );

  assign in_ch.ready = in_ready;

  // checks
  `PN_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ready, !in_ready)
  `PN_ASSERT_IMP(a_div_nonzero, clk, rst_n, cmd.div_step, status.wsum_nz)
  `PN_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !status.out_busy)

endmodule
